// ===== src/vtpd_pkg.sv =====
// Package for the vertex transform block: widths, entry count, action encoding.
// No dependencies.
package vtpd_pkg;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int FIELD_W        = 32;
  localparam int ENTRIES        = 16;
  localparam int IDX_W          = 4;
  localparam int COMPS          = 4;

  typedef enum logic {
    ACT_LOAD      = 1'b0,
    ACT_TRANSFORM = 1'b1
  } action_t;
endpackage

// ===== src/vtpd_if.sv =====
// Valid/ready channel interfaces for the vertex transform block.
// Depends on vtpd_pkg.
interface vtpd_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [vtpd_pkg::IDX_W-1:0]        entry_index;
  logic signed [vtpd_pkg::FIELD_W-1:0] entry_value;
  logic signed [vtpd_pkg::FIELD_W-1:0] in_x;
  logic signed [vtpd_pkg::FIELD_W-1:0] in_y;
  logic signed [vtpd_pkg::FIELD_W-1:0] in_z;
  modport source (output valid, action, entry_index, entry_value, in_x, in_y, in_z,
                  input ready);
  modport sink   (input valid, action, entry_index, entry_value, in_x, in_y, in_z,
                  output ready);
endinterface

interface vtpd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vtpd_pkg::FIELD_W-1:0] out_x;
  logic signed [vtpd_pkg::FIELD_W-1:0] out_y;
  logic signed [vtpd_pkg::FIELD_W-1:0] out_z;
  logic signed [vtpd_pkg::FIELD_W-1:0] out_w;
  logic                              w_was_zero;
  modport source (output valid, out_x, out_y, out_z, out_w, w_was_zero, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, w_was_zero, output ready);
endinterface

// ===== src/vertex_transform_perspective_divide.sv =====
// Top level of the homogeneous vertex transform with perspective divide.
// Throughput: one vertex or one matrix load per cycle; the whole pipe advances when
//   the output register is empty or being taken, so a stall holds every stage.
// Reset: synchronous rst clears the matrix to zero and all valid bits.
// Depends on vtpd_pkg, vtpd_if, vtpd_mul, vtpd_div.
module vertex_transform_perspective_divide #(
  parameter int WORD_WIDTH = vtpd_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = vtpd_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  vtpd_in_if.sink   in_ch,
  vtpd_out_if.source out_ch
);
  localparam int NB  = WORD_WIDTH + FRAC_BITS;
  localparam int IB  = (WORD_WIDTH < vtpd_pkg::FIELD_W) ? WORD_WIDTH : vtpd_pkg::FIELD_W;
  localparam int SW  = WORD_WIDTH + 2;
  // stages: 1 capture, 2-3 multiply, 4 sum, 5 saturate, then divider NB+2, out
  localparam int DLY = NB + 2;
  localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  function automatic logic signed [WORD_WIDTH-1:0] ext(input logic [vtpd_pkg::FIELD_W-1:0] f);
    logic signed [IB-1:0] t;
    t = f[IB-1:0];
    return WORD_WIDTH'(t);
  endfunction

  // Matrix: written by load words; transform words see writes of earlier words.
  logic signed [WORD_WIDTH-1:0] mat [vtpd_pkg::ENTRIES];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vtpd_pkg::ENTRIES; i++) mat[i] <= '0;
    end else if (in_ch.valid && adv && in_ch.action == vtpd_pkg::ACT_LOAD) begin
      mat[in_ch.entry_index] <= ext(in_ch.entry_value);
    end
  end

  // Stage 1: capture vertex and snapshot of the matrix.
  logic v1;
  logic signed [WORD_WIDTH-1:0] vx [3];
  logic signed [WORD_WIDTH-1:0] m1 [vtpd_pkg::ENTRIES];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_ch.valid && in_ch.action == vtpd_pkg::ACT_TRANSFORM;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      vx[0] <= ext(in_ch.in_x);
      vx[1] <= ext(in_ch.in_y);
      vx[2] <= ext(in_ch.in_z);
      m1 <= mat;
    end
  end

  // Stages 2-3: twelve products; hold the translation row alongside.
  logic signed [WORD_WIDTH-1:0] prod [12];
  logic signed [WORD_WIDTH-1:0] tr2 [vtpd_pkg::COMPS];
  logic signed [WORD_WIDTH-1:0] tr3 [vtpd_pkg::COMPS];
  logic v2, v3;
  for (genvar k = 0; k < 3; k++) begin : g_k
    for (genvar c = 0; c < vtpd_pkg::COMPS; c++) begin : g_c
      vtpd_mul #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
        .clk(clk), .en(adv), .a(vx[k]), .b(m1[k*4+c]), .p(prod[k*4+c]));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < vtpd_pkg::COMPS; c++) begin
        tr2[c] <= m1[12+c];
        tr3[c] <= tr2[c];
      end
    end
  end

  // Stage 4: exact four-term sums.
  logic signed [SW-1:0] sum [vtpd_pkg::COMPS];
  logic v4;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < vtpd_pkg::COMPS; c++)
        sum[c] <= SW'(tr3[c]) + SW'(prod[c]) + SW'(prod[4+c]) + SW'(prod[8+c]);
    end
  end

  // Stage 5: saturate, flag zero w.
  logic signed [WORD_WIDTH-1:0] res [vtpd_pkg::COMPS];
  logic v5, wz5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < vtpd_pkg::COMPS; c++) begin
        if (sum[c] > SMAX)      res[c] <= WORD_WIDTH'(SMAX);
        else if (sum[c] < SMIN) res[c] <= WORD_WIDTH'(SMIN);
        else                    res[c] <= WORD_WIDTH'(sum[c]);
      end
    end
  end
  assign wz5 = (res[3] == '0);

  // Divider lanes plus delay line for undivided values, w and flag.
  // The divider holds NB+2 registers (capture, NB bit stages, result).
  logic signed [WORD_WIDTH-1:0] quo [3];
  logic signed [WORD_WIDTH-1:0] den;
  assign den = wz5 ? WORD_WIDTH'(1) : res[3];
  for (genvar c = 0; c < 3; c++) begin : g_div
    vtpd_div #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .en(adv), .n(res[c]), .d(den), .q(quo[c]));
  end

  logic signed [WORD_WIDTH-1:0] dl [DLY][vtpd_pkg::COMPS];
  logic                         dz [DLY];
  logic                         dv [DLY];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLY; i++) dv[i] <= 1'b0;
    end else if (adv) begin
      dv[0] <= v5;
      for (int i = 1; i < DLY; i++) dv[i] <= dv[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dl[0] <= res;
      dz[0] <= wz5;
      for (int i = 1; i < DLY; i++) begin
        dl[i] <= dl[i-1];
        dz[i] <= dz[i-1];
      end
    end
  end

  // Output register: pick quotient or undivided value.
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (adv) out_ch.valid <= dv[DLY-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.out_x <= vtpd_pkg::FIELD_W'(dz[DLY-1] ? dl[DLY-1][0] : quo[0]);
      out_ch.out_y <= vtpd_pkg::FIELD_W'(dz[DLY-1] ? dl[DLY-1][1] : quo[1]);
      out_ch.out_z <= vtpd_pkg::FIELD_W'(dz[DLY-1] ? dl[DLY-1][2] : quo[2]);
      out_ch.out_w <= vtpd_pkg::FIELD_W'(dl[DLY-1][3]);
      out_ch.w_was_zero <= dz[DLY-1];
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.out_x))
    else $error("result word dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && in_ch.action == vtpd_pkg::ACT_LOAD |=> !v1)
    else $error("load word entered transform pipe");
`endif
endmodule

// ===== src/vtpd_mul.sv =====
// Registered fixed-point multiplier stage pair: product, then shift and saturate.
// Depends on vtpd_pkg.
module vtpd_mul #(
  parameter int WORD_WIDTH = vtpd_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = vtpd_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [WORD_WIDTH-1:0] a,
  input  logic signed [WORD_WIDTH-1:0] b,
  output logic signed [WORD_WIDTH-1:0] p
);
  localparam int PW = 2 * WORD_WIDTH;
  localparam logic [PW-1:0] MAXV = PW'((64'd1 << (WORD_WIDTH - 1)) - 64'd1);

  logic [PW-1:0] mag;
  logic          neg;
  logic [PW-1:0] ua, ub, sh, lim;

  assign ua = a[WORD_WIDTH-1] ? PW'(-{{WORD_WIDTH{a[WORD_WIDTH-1]}}, a})
                              : PW'({{WORD_WIDTH{1'b0}}, a});
  assign ub = b[WORD_WIDTH-1] ? PW'(-{{WORD_WIDTH{b[WORD_WIDTH-1]}}, b})
                              : PW'({{WORD_WIDTH{1'b0}}, b});

  // Multiply magnitudes; sign rides alongside.
  always_ff @(posedge clk) begin
    if (en) begin
      mag <= PW'(ua[WORD_WIDTH-1:0] * ub[WORD_WIDTH-1:0]);
      neg <= a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
    end
  end

  assign sh  = mag >> FRAC_BITS;
  assign lim = neg ? MAXV + PW'(1) : MAXV;

  always_ff @(posedge clk) begin
    if (en) begin
      if (sh > lim) p <= neg ? -WORD_WIDTH'(lim) : WORD_WIDTH'(lim);
      else          p <= neg ? -WORD_WIDTH'(sh)  : WORD_WIDTH'(sh);
    end
  end
endmodule

// ===== src/vtpd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// Depends on vtpd_pkg.
module vtpd_div #(
  parameter int WORD_WIDTH = vtpd_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = vtpd_pkg::FRAC_BITS_DEF,
  localparam int NB = WORD_WIDTH + FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [WORD_WIDTH-1:0] n,
  input  logic signed [WORD_WIDTH-1:0] d,
  output logic signed [WORD_WIDTH-1:0] q
);
  localparam int RW = WORD_WIDTH + 1;
  localparam logic [NB:0] MAXV = (NB+1)'((64'd1 << (WORD_WIDTH - 1)) - 64'd1);

  logic [WORD_WIDTH-1:0] num_s [NB+1];
  logic [WORD_WIDTH-1:0] den_s [NB+1];
  logic [RW-1:0]         rem_s [NB+1];
  logic [NB:0]           quo_s [NB+1];
  logic                  neg_s [NB+1];

  logic [WORD_WIDTH-1:0] un, ud;
  assign un = n[WORD_WIDTH-1] ? -n : n;
  assign ud = d[WORD_WIDTH-1] ? -d : d;

  always_ff @(posedge clk) begin
    if (en) begin
      num_s[0] <= un;
      den_s[0] <= ud;
      rem_s[0] <= '0;
      quo_s[0] <= '0;
      neg_s[0] <= n[WORD_WIDTH-1] ^ d[WORD_WIDTH-1];
    end
  end

  // One quotient bit per stage, numerator bits then FRAC_BITS zeros.
  for (genvar s = 0; s < NB; s++) begin : g_st
    localparam int P = NB - 1 - s;
    logic [RW:0] r2;
    logic        bi;
    if (P >= FRAC_BITS) begin : g_b
      assign bi = num_s[s][P-FRAC_BITS];
    end else begin : g_z
      assign bi = 1'b0;
    end
    assign r2 = {rem_s[s], bi};
    always_ff @(posedge clk) begin
      if (en) begin
        num_s[s+1] <= num_s[s];
        den_s[s+1] <= den_s[s];
        neg_s[s+1] <= neg_s[s];
        if (r2 >= {2'b0, den_s[s]}) begin
          rem_s[s+1] <= RW'(r2 - {2'b0, den_s[s]});
          quo_s[s+1] <= {quo_s[s][NB-1:0], 1'b1};
        end else begin
          rem_s[s+1] <= RW'(r2);
          quo_s[s+1] <= {quo_s[s][NB-1:0], 1'b0};
        end
      end
    end
  end

  logic [NB:0] lim;
  assign lim = neg_s[NB] ? MAXV + (NB+1)'(1) : MAXV;

  always_ff @(posedge clk) begin
    if (en) begin
      if (quo_s[NB] > lim) q <= neg_s[NB] ? -WORD_WIDTH'(lim) : WORD_WIDTH'(lim);
      else q <= neg_s[NB] ? -WORD_WIDTH'(quo_s[NB]) : WORD_WIDTH'(quo_s[NB]);
    end
  end
endmodule

// ===== tb/vertex_transform_perspective_divide_tb.sv =====
// Self-checking testbench for vertex_transform_perspective_divide: matrix loads
// and vertex transforms go in, projected vertices are checked against a predictor.
// Depends on vtpd_pkg, vtpd_if and the block's RTL.
module vertex_transform_perspective_divide_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAC      = 16;
  localparam int          DRAIN_CYC = 70;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  typedef struct {
    vtpd_pkg::action_t                act;
    logic [vtpd_pkg::IDX_W-1:0]       idx;
    logic signed [31:0]     val;
    logic signed [31:0]     x, y, z;
  } word_t;

  typedef struct {
    logic signed [31:0] x, y, z, w;
    logic               w_zero;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vtpd_in_if  in_ch();
  vtpd_out_if out_ch();

  vertex_transform_perspective_divide uut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's matrix and the projected vertices still in flight.
  logic signed [31:0] matrix_shadow [vtpd_pkg::ENTRIES];
  vertex_t            pending_vertices [$];
  int                 mismatches = 0;
  bit                 gaps_on    = 1'b1;  // clear for back-to-back stretches
  int                 sink_hold  = 0;     // long receiver hold-off, in cycles

  // ---------------------------------------------------------------------------
  // Predictor: Q16.16 multiply, sum, then divide by w with saturation; a zero w is not divided.
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] clamp_q(longint s);
    if (s > longint'(Q_MAX)) return Q_MAX;
    if (s < longint'(Q_MIN)) return Q_MIN;
    return s[31:0];
  endfunction

  // Truncate the magnitude toward zero, then restore the sign.
  function automatic logic signed [31:0] q_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p, m;
    p = longint'(a) * longint'(b);
    m = (p < 0) ? -p : p;
    m = m >>> FRAC;
    return clamp_q((p < 0) ? -m : m);
  endfunction

  function automatic logic signed [31:0] q_div(logic signed [31:0] n, logic signed [31:0] d);
    longint q;
    q = (longint'(n) <<< FRAC) / longint'(d);
    return clamp_q(q);
  endfunction

  function automatic vertex_t project_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                             logic signed [31:0] z);
    vertex_t            v;
    logic signed [31:0] comp [4];
    longint             s;
    for (int c = 0; c < vtpd_pkg::COMPS; c++) begin
      s = longint'(matrix_shadow[12 + c]);
      s += longint'(q_mul(x, matrix_shadow[c]));
      s += longint'(q_mul(y, matrix_shadow[4 + c]));
      s += longint'(q_mul(z, matrix_shadow[8 + c]));
      comp[c] = clamp_q(s);
    end
    v.w      = comp[3];
    v.w_zero = (comp[3] == 0);
    // Zero w: pass the sums through undivided.
    v.x = v.w_zero ? comp[0] : q_div(comp[0], comp[3]);
    v.y = v.w_zero ? comp[1] : q_div(comp[1], comp[3]);
    v.z = v.w_zero ? comp[2] : q_div(comp[2], comp[3]);
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mix of full-range words, modest Q16.16 values and edge values.
  function automatic logic signed [31:0] rand_q();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom;
    if (r < 8) return $signed($urandom_range(0, 16 << FRAC)) - (8 << FRAC);
    case ($urandom_range(0, 5))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 0;
      3: return 1;
      4: return -1;
      default: return ($urandom_range(0, 1) != 0) ? Q_ONE : -Q_ONE;
    endcase
  endfunction

  function automatic word_t load_word(int idx, logic signed [31:0] val);
    word_t w;
    w.act = vtpd_pkg::ACT_LOAD;
    w.idx = idx[vtpd_pkg::IDX_W-1:0];
    w.val = val;
    w.x   = $urandom;  // ignored on loads
    w.y   = $urandom;
    w.z   = $urandom;
    return w;
  endfunction

  function automatic word_t vertex_word(logic signed [31:0] x, logic signed [31:0] y,
                                        logic signed [31:0] z);
    word_t w;
    w.act = vtpd_pkg::ACT_TRANSFORM;
    // ignored on transforms
    w.idx = vtpd_pkg::IDX_W'($urandom_range(0, vtpd_pkg::ENTRIES - 1));
    w.val = $urandom;
    w.x   = x;
    w.y   = y;
    w.z   = z;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: change inputs at the falling edge, take the handshake at the rising.
  // ---------------------------------------------------------------------------
  task automatic send_word(word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.action      = w.act;
    in_ch.entry_index = w.idx;
    in_ch.entry_value = w.val;
    in_ch.in_x        = w.x;
    in_ch.in_y        = w.y;
    in_ch.in_z        = w.z;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    // Accepted: update the shadow or queue the projected vertex.
    if (w.act == vtpd_pkg::ACT_LOAD) matrix_shadow[w.idx] = w.val;
    else pending_vertices.push_back(project_vertex(w.x, w.y, w.z));
    @(negedge clk);
  endtask

  task automatic load_matrix(logic signed [31:0] m [vtpd_pkg::ENTRIES]);
    for (int i = 0; i < vtpd_pkg::ENTRIES; i++) send_word(load_word(i, m[i]));
  endtask

  task automatic send_random(int count);
    logic signed [31:0] m [vtpd_pkg::ENTRIES];
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 199) == 0) begin
        // Fresh, well-behaved matrix so w is usually nonzero.
        foreach (m[i]) m[i] = $signed($urandom_range(0, 4 << FRAC)) - (2 << FRAC);
        load_matrix(m);
      end else if ($urandom_range(0, 9) == 0) begin
        send_word(load_word($urandom_range(0, vtpd_pkg::ENTRIES - 1), rand_q()));
      end else begin
        send_word(vertex_word(rand_q(), rand_q(), rand_q()));
      end
    end
    in_ch.valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_ch.ready = 1'b0;
        sink_hold--;
      end else if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Checker: compare each result word with the oldest pending vertex.
  always @(posedge clk) begin
    vertex_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected result word x=%h w=%h", out_ch.out_x, out_ch.out_w);
        mismatches++;
      end else begin
        e = pending_vertices.pop_front();
        if (out_ch.out_x !== e.x) begin
          $error("out_x expected %h got %h", e.x, out_ch.out_x); mismatches++;
        end
        if (out_ch.out_y !== e.y) begin
          $error("out_y expected %h got %h", e.y, out_ch.out_y); mismatches++;
        end
        if (out_ch.out_z !== e.z) begin
          $error("out_z expected %h got %h", e.z, out_ch.out_z); mismatches++;
        end
        if (out_ch.out_w !== e.w) begin
          $error("out_w expected %h got %h", e.w, out_ch.out_w); mismatches++;
        end
        if (out_ch.w_was_zero !== e.w_zero) begin
          $error("w_was_zero expected %b got %b", e.w_zero, out_ch.w_was_zero);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Matrix is all zero after reset: w is zero and the flag is set.
  task automatic test_reset_matrix();
    send_word(vertex_word(Q_ONE, -Q_ONE, Q_MAX));
    in_ch.valid = 1'b0;
  endtask

  // Identity, perspective (w = z), zero w, and saturation of products, sums and quotients.
  task automatic test_directed();
    logic signed [31:0] m [vtpd_pkg::ENTRIES];
    foreach (m[i]) m[i] = ((i % 5) == 0) ? Q_ONE : 32'sd0;
    load_matrix(m);
    send_word(vertex_word(Q_MAX, Q_MIN, 0));
    send_word(vertex_word(3 <<< FRAC, -(5 <<< FRAC), 1));
    // Perspective: w taken from z.
    send_word(load_word(15, 0));
    send_word(load_word(11, Q_ONE));
    send_word(vertex_word(4 <<< FRAC, 2 <<< FRAC, 0));        // zero w
    send_word(vertex_word(4 <<< FRAC, -(2 <<< FRAC), 2 <<< FRAC));
    send_word(vertex_word(Q_MAX, Q_MIN, 1));                   // quotient saturates
    send_word(vertex_word(-(7 <<< FRAC), 1 <<< FRAC, -(3 <<< FRAC)));
    // Products and sums saturate.
    send_word(load_word(0, Q_MAX));
    send_word(load_word(4, Q_MIN));
    send_word(vertex_word(Q_MAX, Q_MAX, Q_ONE));
    send_word(vertex_word(Q_MIN, Q_MIN, -Q_ONE));
    send_word(vertex_word(Q_MIN, Q_MAX, Q_MIN));
    in_ch.valid = 1'b0;
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    send_random(120);
    gaps_on = 1'b1;
  endtask

  // Hold the receiver off long enough for the pipe to fill and stall the input.
  task automatic test_backpressure();
    sink_hold = 300;
    send_random(150);
  endtask

  task automatic test_random();
    send_random(750);
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.action      = vtpd_pkg::ACT_LOAD;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    in_ch.in_x        = '0;
    in_ch.in_y        = '0;
    in_ch.in_z        = '0;
    out_ch.ready      = 1'b0;
    foreach (matrix_shadow[i]) matrix_shadow[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_matrix();
    test_directed();
    test_back_to_back();
    test_backpressure();
    test_random();

    // Drain: wait for every pending vertex, then let the pipe settle.
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0) $display("vertex_transform_perspective_divide_tb OK");
    else $display("vertex_transform_perspective_divide_tb NOT OK");
    $finish;
  end

  initial begin
    #5ms;
    $display("vertex_transform_perspective_divide_tb NOT OK");
    $finish;
  end
endmodule
